@@ sv/bres_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Bresenham line rasterizer: payload structs, line state and
// octant decode helpers. No dependencies.
package bres_pkg;

  localparam int COORD_BITS = 11;
  localparam int COLOR_BITS = 4;
  localparam int INC_BITS   = COORD_BITS + 2;
  localparam int DEC_BITS   = COORD_BITS + 3;

  // Octants are named by the direction of the major step: east is +x, north is +y.
  typedef enum logic [2:0] {
    OCT_ENE = 3'd0,
    OCT_NNE = 3'd1,
    OCT_NNW = 3'd2,
    OCT_WNW = 3'd3,
    OCT_WSW = 3'd4,
    OCT_SSW = 3'd5,
    OCT_SSE = 3'd6,
    OCT_ESE = 3'd7
  } octant_t;

  typedef struct packed {
    logic                  mode;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_value;
    logic                  is_last;
  } out_item_t;

  typedef struct packed {
    logic                       active;
    logic [COORD_BITS-1:0]      cur_x;
    logic [COORD_BITS-1:0]      cur_y;
    logic signed [DEC_BITS-1:0] decision;
    logic signed [INC_BITS-1:0] inc_straight;
    logic signed [INC_BITS-1:0] inc_diagonal;
    octant_t                    octant;
    logic [COORD_BITS-1:0]      steps_left;
  } line_state_t;

  // True when x is the major axis of the octant.
  function automatic logic oct_x_major(octant_t k);
    logic r;
    unique case (k)
      OCT_ENE, OCT_WNW, OCT_WSW, OCT_ESE: r = 1'b1;
      OCT_NNE, OCT_NNW, OCT_SSW, OCT_SSE: r = 1'b0;
    endcase
    return r;
  endfunction

  // True when x steps toward smaller values.
  function automatic logic oct_x_neg(octant_t k);
    logic r;
    unique case (k)
      OCT_NNW, OCT_WNW, OCT_WSW, OCT_SSW: r = 1'b1;
      OCT_ENE, OCT_NNE, OCT_SSE, OCT_ESE: r = 1'b0;
    endcase
    return r;
  endfunction

  // True when y steps toward smaller values.
  function automatic logic oct_y_neg(octant_t k);
    logic r;
    unique case (k)
      OCT_WSW, OCT_SSW, OCT_SSE, OCT_ESE: r = 1'b1;
      OCT_ENE, OCT_NNE, OCT_NNW, OCT_WNW: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/bres_setup.sv @@
`timescale 1ns / 1ps
// Line setup logic: octant choice, decision variable and increments for a load.
// Depends on bres_pkg.
module bres_setup
  import bres_pkg::*;
(
  input  in_item_t    item,
  output line_state_t setup,
  output logic        is_last
);

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS:0]        adx_w;
  logic [COORD_BITS:0]        ady_w;
  logic [COORD_BITS-1:0]      adx;
  logic [COORD_BITS-1:0]      ady;
  logic                       dx_neg;
  logic                       dy_neg;
  logic                       dx_pos;
  logic                       dy_pos;
  logic                       x_major;
  logic [COORD_BITS-1:0]      major;
  logic [COORD_BITS-1:0]      minor;
  octant_t                    k;

  always_comb begin
    dx     = $signed({1'b0, item.x_end}) - $signed({1'b0, item.x_start});
    dy     = $signed({1'b0, item.y_end}) - $signed({1'b0, item.y_start});
    dx_neg = dx[COORD_BITS];
    dy_neg = dy[COORD_BITS];
    dx_pos = !dx_neg && (dx != '0);
    dy_pos = !dy_neg && (dy != '0);
    adx_w  = dx_neg ? $unsigned(-dx) : $unsigned(dx);
    ady_w  = dy_neg ? $unsigned(-dy) : $unsigned(dy);
    adx    = adx_w[COORD_BITS-1:0];
    ady    = ady_w[COORD_BITS-1:0];

    // On an exact diagonal x leads when both deltas point the same way.
    x_major = (adx > ady) || ((adx == ady) && (dx_pos == dy_pos));
    major   = x_major ? adx : ady;
    minor   = x_major ? ady : adx;

    if (x_major) begin
      k = dx_neg ? (dy_neg ? OCT_WSW : OCT_WNW) : (dy_neg ? OCT_ESE : OCT_ENE);
    end else begin
      k = dy_neg ? (dx_neg ? OCT_SSW : OCT_SSE) : (dx_neg ? OCT_NNW : OCT_NNE);
    end

    setup.active       = (major != '0);
    setup.cur_x        = item.x_start;
    setup.cur_y        = item.y_start;
    setup.decision     = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
    setup.inc_straight = $signed({1'b0, minor, 1'b0});
    setup.inc_diagonal = $signed({1'b0, minor, 1'b0}) - $signed({1'b0, major, 1'b0});
    setup.octant       = k;
    setup.steps_left   = major;
    is_last            = (major == '0);
  end

endmodule

@@ sv/bres_step.sv @@
`timescale 1ns / 1ps
// One Bresenham step: decision update and major/minor axis moves.
// Depends on bres_pkg.
module bres_step
  import bres_pkg::*;
(
  input  line_state_t cur,
  output line_state_t nxt,
  output logic        is_last
);

  logic                       diag;
  logic                       x_major;
  logic                       move_x;
  logic                       move_y;
  logic signed [DEC_BITS-1:0] inc;
  logic [COORD_BITS-1:0]      steps_next;

  always_comb begin
    diag    = !cur.decision[DEC_BITS-1];
    x_major = oct_x_major(cur.octant);
    move_x  = x_major || diag;
    move_y  = !x_major || diag;
    inc     = diag ? DEC_BITS'(cur.inc_diagonal) : DEC_BITS'(cur.inc_straight);

    // An active line always has at least one step left.
    steps_next = cur.steps_left - COORD_BITS'(1);

    nxt              = cur;
    nxt.decision     = cur.decision + inc;
    nxt.steps_left   = steps_next;
    nxt.active       = (steps_next != '0);
    if (move_x) begin
      nxt.cur_x = oct_x_neg(cur.octant) ? cur.cur_x - COORD_BITS'(1)
                                        : cur.cur_x + COORD_BITS'(1);
    end
    if (move_y) begin
      nxt.cur_y = oct_y_neg(cur.octant) ? cur.cur_y - COORD_BITS'(1)
                                        : cur.cur_y + COORD_BITS'(1);
    end
    is_last = (steps_next == '0);
  end

endmodule

@@ sv/bresenham_line_rasterizer_top.sv @@
`timescale 1ns / 1ps
// Bresenham line rasterizer, all eight octants, at most one pixel per transfer.
// A pixel passes through the input register and then the result register.
// Throughput: one item per cycle; the input side stalls only while the result register is held.
// Reset (synchronous, active high) ends any line in progress, clears the color to zero and
// empties both pipeline registers. Depends on bres_pkg, bres_setup and bres_step.
module bresenham_line_rasterizer_top
  import bres_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  in_item_t              item,
  output logic                  pixel_valid,
  input  logic                  pixel_stall,
  output out_item_t             pixel,
  input  logic                  cfg_we,
  input  logic [COLOR_BITS-1:0] cfg_data
);

  // Color register, to be written only while the block is idle; the block itself does not enforce this.
  logic [COLOR_BITS-1:0] pixel_color;

  // Input register stage.
  logic     s1_valid;
  in_item_t s1_item;

  // Line state carried from one transfer to the next.
  line_state_t line;

  line_state_t setup_state;
  logic        setup_last;
  line_state_t step_state;
  logic        step_last;

  logic out_free;
  logic exec;

  bres_setup u_setup (
    .item    (s1_item),
    .setup   (setup_state),
    .is_last (setup_last)
  );

  bres_step u_step (
    .cur     (line),
    .nxt     (step_state),
    .is_last (step_last)
  );

  // The result register can take a new pixel when it is empty or being drained
  // this cycle. The item in the input register executes exactly then, and the
  // input side is stalled only while an item waits there for a held result.
  assign out_free   = !pixel_valid || !pixel_stall;
  assign exec       = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_color <= '0;
    end else if (cfg_we) begin
      pixel_color <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1_item <= item;
    end
  end

  // Execution: a load always emits its start pixel and replaces any line in
  // progress; an advance emits the next pixel only while a line is active,
  // and otherwise is consumed with no result.
  always_ff @(posedge clk) begin
    if (rst) begin
      line        <= '0;
      pixel_valid <= 1'b0;
    end else if (exec) begin
      if (!s1_item.mode) begin
        line        <= setup_state;
        pixel_valid <= 1'b1;
      end else if (line.active) begin
        line        <= step_state;
        pixel_valid <= 1'b1;
      end else begin
        pixel_valid <= 1'b0;
      end
    end else if (out_free) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      if (!s1_item.mode) begin
        pixel.pixel_x     <= setup_state.cur_x;
        pixel.pixel_y     <= setup_state.cur_y;
        pixel.pixel_value <= pixel_color;
        pixel.is_last     <= setup_last;
      end else if (line.active) begin
        pixel.pixel_x     <= step_state.cur_x;
        pixel.pixel_y     <= step_state.cur_y;
        pixel.pixel_value <= pixel_color;
        pixel.is_last     <= step_last;
      end
    end
  end

endmodule
